// File: hdl/assert_macros.svh
// Assertion macros used by the qualifier top level.
// No dependencies; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define GEPQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define GEPQ_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define GEPQ_ASSERT(lbl, clk, rst, prop)
`define GEPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hdl/gepq_pkg.sv
// Types, codes and the button table of the gamepad event qualifier.
// No dependencies.
package gepq_pkg;

   localparam int TIME_BITS   = 32;
   localparam int OP_W        = 3;
   localparam int NOW_W       = 32;
   localparam int BUTTON_W    = 5;
   localparam int ACTION_W    = 4;
   localparam int AXIS_W      = 3;
   localparam int AXIS_VAL_W  = 16;
   localparam int DELAY_W     = 16;
   localparam int PERIOD_W    = 16;
   localparam int THRESH_W    = 15;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int NUM_DIRS    = 4;
   localparam int DIR_IDX_W   = 2;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [ACTION_W-1:0]  action_type;

   localparam logic [OP_W-1:0] OP_IDLE     = 3'd0;
   localparam logic [OP_W-1:0] OP_QUIT     = 3'd1;
   localparam logic [OP_W-1:0] OP_KEY_DOWN = 3'd2;
   localparam logic [OP_W-1:0] OP_BTN_DOWN = 3'd3;
   localparam logic [OP_W-1:0] OP_BTN_UP   = 3'd4;
   localparam logic [OP_W-1:0] OP_AXIS     = 3'd5;
   localparam logic [OP_W-1:0] OP_REMOVED  = 3'd6;

   localparam action_type ACT_NONE  = 4'd0;
   localparam action_type ACT_UP    = 4'd1;
   localparam action_type ACT_RIGHT = 4'd4;
   localparam action_type ACT_L2    = 4'd11;
   localparam action_type ACT_R2    = 4'd12;
   localparam action_type ACT_QUIT  = 4'd15;

   localparam logic [BUTTON_W-1:0] BTN_BACK  = 5'd4;
   localparam logic [BUTTON_W-1:0] BTN_START = 5'd6;

   localparam logic [AXIS_W-1:0] AXIS_LEFT_TRIG  = 3'd4;
   localparam logic [AXIS_W-1:0] AXIS_RIGHT_TRIG = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_DELAY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIG_THRESH   = 2'd2;

   localparam logic [DELAY_W-1:0]  DELAY_RESET  = 16'd350;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd70;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd16384;

   typedef struct packed {
      logic [OP_W-1:0]              operation;
      logic [NOW_W-1:0]             now_ms;
      logic [BUTTON_W-1:0]          button;
      action_type                   key_action;
      logic                         key_repeat;
      logic [AXIS_W-1:0]            axis;
      logic signed [AXIS_VAL_W-1:0] axis_value;
      logic                         removed_is_active;
   } req_item_type;

   typedef struct packed {
      logic       has_event;
      action_type action;
   } rsp_item_type;

   typedef struct packed {
      logic [DELAY_W-1:0]  repeat_delay_ms;
      logic [PERIOD_W-1:0] repeat_period_ms;
      logic [THRESH_W-1:0] trig_level;
   } cfg_type;

   function automatic action_type button_action(input logic [BUTTON_W-1:0] btn);
      action_type act;
      case (btn)
         5'd0:    act = 4'd5;
         5'd1:    act = 4'd6;
         5'd2:    act = 4'd7;
         5'd3:    act = 4'd8;
         5'd4:    act = 4'd14;
         5'd5:    act = 4'd15;
         5'd6:    act = 4'd13;
         5'd9:    act = 4'd9;
         5'd10:   act = 4'd10;
         5'd11:   act = 4'd1;
         5'd12:   act = 4'd2;
         5'd13:   act = 4'd3;
         5'd14:   act = 4'd4;
         default: act = ACT_NONE;
      endcase
      return act;
   endfunction

endpackage

// File: hdl/gepq_if.sv
// Request and response channel interfaces of the qualifier.
// Depends on gepq_pkg.
interface gepq_req_if;
   import gepq_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [OP_W-1:0]              operation;
   logic [NOW_W-1:0]             now_ms;
   logic [BUTTON_W-1:0]          button;
   logic [ACTION_W-1:0]          key_action;
   logic                         key_repeat;
   logic [AXIS_W-1:0]            axis;
   logic signed [AXIS_VAL_W-1:0] axis_value;
   logic                         removed_is_active;

   modport source (output valid, operation, now_ms, button, key_action, key_repeat,
                   axis, axis_value, removed_is_active, input ready);
   modport sink (input valid, operation, now_ms, button, key_action, key_repeat,
                 axis, axis_value, removed_is_active, output ready);
endinterface

interface gepq_rsp_if;
   import gepq_pkg::*;
   logic                valid;
   logic                ready;
   logic                has_event;
   logic [ACTION_W-1:0] action;

   modport source (output valid, has_event, action, input ready);
   modport sink (input valid, has_event, action, output ready);
endinterface

// File: hdl/gepq_csr.sv
// Configuration registers: repeat delay, repeat period, trigger threshold.
// Depends on gepq_pkg.
module gepq_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [gepq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gepq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output gepq_pkg::cfg_type                cfg
);
   import gepq_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_REPEAT_DELAY:  cfg_in.repeat_delay_ms   = csr_wdata[DELAY_W-1:0];
            CSR_REPEAT_PERIOD: cfg_in.repeat_period_ms  = csr_wdata[PERIOD_W-1:0];
            CSR_TRIG_THRESH:   cfg_in.trig_level        = csr_wdata[THRESH_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_delay_ms   <= DELAY_RESET;
         cfg_ff.repeat_period_ms  <= PERIOD_RESET;
         cfg_ff.trig_level        <= THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/gepq_core.sv
// Event mapping and repeat state: hold bits, trigger edges, repeat times.
// Depends on gepq_pkg.
module gepq_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  gepq_pkg::req_item_type  item,
   input  gepq_pkg::cfg_type       cfg,
   output gepq_pkg::rsp_item_type  result
);
   import gepq_pkg::*;

   logic [NUM_DIRS-1:0] held_ff, held_in;
   time_type            next_ff [NUM_DIRS];
   time_type            next_in [NUM_DIRS];
   logic                start_ff, start_in;
   logic                select_ff, select_in;
   logic                ltrig_ff, ltrig_in;
   logic                rtrig_ff, rtrig_in;

   time_type            now_t;
   time_type            diff [NUM_DIRS];
   logic [NUM_DIRS-1:0] due;
   logic                found;
   logic                trig_down;
   action_type          act;
   action_type          mapped;
   logic [DIR_IDX_W-1:0] dir_idx;

   assign now_t  = time_type'(item.now_ms);
   assign mapped = button_action(item.button);
   assign dir_idx = DIR_IDX_W'(mapped - ACT_UP);
   assign trig_down = item.axis_value >
                      $signed({1'b0, cfg.trig_level});

   always_comb begin
      for (int i = 0; i < NUM_DIRS; i++) begin
         diff[i] = now_t - next_ff[i];
         due[i]  = held_ff[i] && !diff[i][TIME_BITS-1];
      end
   end

   always_comb begin
      held_in   = held_ff;
      next_in   = next_ff;
      start_in  = start_ff;
      select_in = select_ff;
      ltrig_in  = ltrig_ff;
      rtrig_in  = rtrig_ff;
      found     = 1'b0;
      act       = ACT_NONE;
      result.has_event = 1'b1;
      case (item.operation)
         OP_IDLE: begin
            for (int i = 0; i < NUM_DIRS; i++) begin
               if (!found && due[i]) begin
                  found      = 1'b1;
                  next_in[i] = now_t + time_type'(cfg.repeat_period_ms);
                  act        = ACT_UP + ACTION_W'(i);
               end
            end
            result.has_event = found;
         end
         OP_QUIT: act = ACT_QUIT;
         OP_KEY_DOWN: begin
            act = item.key_action;
            if (item.key_repeat && !(act inside {[ACT_UP:ACT_RIGHT]}))
               act = ACT_NONE;
         end
         OP_BTN_DOWN: begin
            act = mapped;
            if (mapped inside {[ACT_UP:ACT_RIGHT]}) begin
               held_in[dir_idx] = 1'b1;
               next_in[dir_idx] = now_t + time_type'(cfg.repeat_delay_ms);
            end
            if (item.button == BTN_START) start_in = 1'b1;
            if (item.button == BTN_BACK) select_in = 1'b1;
            if (start_in && select_in) act = ACT_QUIT;
         end
         OP_BTN_UP: begin
            if (mapped inside {[ACT_UP:ACT_RIGHT]}) held_in[dir_idx] = 1'b0;
            if (item.button == BTN_START) start_in = 1'b0;
            if (item.button == BTN_BACK) select_in = 1'b0;
         end
         OP_AXIS: begin
            if (item.axis == AXIS_LEFT_TRIG) begin
               if (trig_down && !ltrig_ff) act = ACT_L2;
               ltrig_in = trig_down;
            end else if (item.axis == AXIS_RIGHT_TRIG) begin
               if (trig_down && !rtrig_ff) act = ACT_R2;
               rtrig_in = trig_down;
            end
         end
         OP_REMOVED: begin
            if (item.removed_is_active) held_in = '0;
         end
         default: act = ACT_NONE;
      endcase
      result.action = act;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         start_ff  <= 1'b0;
         select_ff <= 1'b0;
         ltrig_ff  <= 1'b0;
         rtrig_ff  <= 1'b0;
         for (int i = 0; i < NUM_DIRS; i++) next_ff[i] <= '0;
      end else if (step_en) begin
         held_ff   <= held_in;
         start_ff  <= start_in;
         select_ff <= select_in;
         ltrig_ff  <= ltrig_in;
         rtrig_ff  <= rtrig_in;
         next_ff   <= next_in;
      end
   end

endmodule

// File: hdl/gamepad_event_qualifier_autorepeat.sv
// Top level of the gamepad event qualifier with direction auto-repeat.
// Depends on gepq_pkg, gepq_if, gepq_csr, gepq_core, assert_macros.svh.
//
// Usage:
//   req_bus  - sink channel, one event per beat (valid/ready).
//   rsp_bus  - source channel, exactly one result beat per request beat.
//   csr_*    - write-only config port: index 0 repeat delay, 1 repeat period,
//              2 trigger threshold; write only while no beat is in flight.
// Path: an accepted request beat lands in the input register, is evaluated
//   against the repeat state, and its result is registered in the result
//   register. Throughput is one beat per cycle while rsp_bus.ready is high;
//   the single evaluation stage between the input and result registers sets it.
// Reset (synchronous): config returns to 350 / 70 / 16384, all hold bits,
//   trigger states and repeat times clear, both channels empty.
// Receiver stall: the result register holds, the input register fills and
//   then req_bus.ready drops until rsp_bus.ready returns; nothing is lost.
`include "assert_macros.svh"

module gamepad_event_qualifier_autorepeat (
   input  logic                             clock,
   input  logic                             reset,
   gepq_req_if.sink                         req_bus,
   gepq_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [gepq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gepq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gepq_pkg::*;

   cfg_type      cfg;
   req_item_type req_ff, req_in;
   logic         req_valid_ff;
   rsp_item_type rsp_ff, rsp_step;
   logic         rsp_valid_ff;
   logic         advance;
   logic         req_take;

   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   always_comb begin
      req_in.operation         = req_bus.operation;
      req_in.now_ms            = req_bus.now_ms;
      req_in.button            = req_bus.button;
      req_in.key_action        = req_bus.key_action;
      req_in.key_repeat        = req_bus.key_repeat;
      req_in.axis              = req_bus.axis;
      req_in.axis_value        = req_bus.axis_value;
      req_in.removed_is_active = req_bus.removed_is_active;
   end

   gepq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gepq_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (req_ff),
      .cfg     (cfg),
      .result  (rsp_step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) req_valid_ff <= req_bus.valid;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
      end
      if (req_take) req_ff <= req_in;
      if (advance) rsp_ff <= rsp_step;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.has_event = rsp_ff.has_event;
   assign rsp_bus.action    = rsp_ff.action;

   `GEPQ_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid_ff && !req_valid_ff)
   `GEPQ_ASSERT(a_ready_only_full, clock, reset, !req_bus.ready |-> req_valid_ff && rsp_valid_ff && !rsp_bus.ready)
   `GEPQ_ASSERT(a_stall_holds_item, clock, reset, (req_valid_ff && !advance) |=> req_valid_ff && $stable(req_ff))
   `GEPQ_ASSERT(a_no_event_no_action, clock, reset, (rsp_valid_ff && !rsp_ff.has_event) |-> rsp_ff.action == ACT_NONE)

endmodule
